>>> design/cpi_pkg.sv
// shared constants and widths for the colour palette indexer
package cpi_pkg;

	// number of palette slots
	localparam int PALETTE_DEPTH = 256;

	// slot address and colour count widths
	localparam int IDX_W   = $clog2(PALETTE_DEPTH);
	localparam int COUNT_W = IDX_W + 1;

	// width used to compare a requested slot number against the count
	localparam int CMP_W = (COUNT_W > 8) ? COUNT_W : 8;

	// grey level is the quotient of this full-scale value by the index
	localparam int          GREY_W    = 8;
	localparam int          GSTEP_W   = $clog2(GREY_W);
	localparam [GREY_W-1:0] GREY_FULL = 8'hFF;

	// stream payload widths
	localparam int RGB_W      = 24;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	// item kinds carried on the input tuser
	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_READ     = 1'b1;

endpackage

>>> design/colour_palette_indexer.sv
// colour palette indexer: palette store, sequential search and grey level divider
//
// Usage: each input transfer is one item. tuser selects classify (0) or read (1).
// A classify item searches the stored palette in first-seen order with one
// comparator, one slot per cycle out of the single read port of the palette memory. A new
// colour is appended while room remains; a full palette drops it and flags it.
// The grey level (255 / index, 0 for index 0) comes from a restoring divider
// that produces one quotient bit per cycle.
// A read item returns one stored slot and whether it lies below the count.
// The block takes one item at a time: s_tready is high only while idle.
// Reset clears the colour count and all control state; the palette memory is
// not cleared, since only slots below the count ever reach a result.
// A finished result sits in the output register; when the receiver stalls,
// the block holds the next result until that register is free and takes no
// new item meanwhile; a new item may be accepted while a result waits there.
module colour_palette_indexer
	import cpi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// red [7:0], green [15:8], blue [23:16], entry_index [31:24]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode [0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// colour_index [7:0], grey_level [15:8], was_new [16], dropped_full [17],
	// entry_red [25:18], entry_green [33:26], entry_blue [41:34],
	// entry_valid [42], colour_count [51:43], zero [55:52]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_RDREQ,
		S_DONE
	} state_t;

	state_t                state_q;
	logic                  op_q;
	logic [RGB_W-1:0]      pix_q;
	logic [IDX_W-1:0]      ent_q;
	logic                  ent_valid_q;
	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    scan_q;
	logic                  cmp_valid_q;
	logic [IDX_W-1:0]      cmp_addr_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      rem_q;
	logic [GREY_W-1:0]     quot_q;
	logic [GSTEP_W-1:0]    step_q;
	logic                  new_q;
	logic                  drop_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [RGB_W-1:0]      mem_q [PALETTE_DEPTH];
	logic [RGB_W-1:0]      rd_data_q;

	logic                  in_xfer;
	logic                  issue;
	logic                  hit;
	logic                  miss;
	logic                  room;
	logic                  wr_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W:0]        trial;
	logic                  ge;
	logic [IDX_W:0]        diff;
	logic                  out_free;
	logic [RGB_W-1:0]      ent_rgb;
	logic [7:0]            res_idx;
	logic [GREY_W-1:0]     res_grey;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// search control: one slot read per cycle, each compared in the cycle after its read
	assign issue = (state_q == S_SCAN) && (scan_q < count_q) && !hit;
	assign hit   = cmp_valid_q && (rd_data_q == pix_q);
	assign miss  = (state_q == S_SCAN) && !cmp_valid_q && (scan_q >= count_q);
	assign room  = (count_q < COUNT_W'(PALETTE_DEPTH));
	assign wr_en = miss && room;

	// single read port shared by the search and the slot read
	assign rd_addr = (state_q == S_RDREQ) ? ent_q : scan_q[IDX_W-1:0];

	// restoring divider step, one quotient bit per cycle
	assign trial = {rem_q, GREY_FULL[GREY_W - 1 - int'(step_q)]};
	assign diff  = trial - {1'b0, idx_q};
	assign ge    = (trial >= {1'b0, idx_q});

	// result fields, unused ones forced to zero
	assign ent_rgb  = (op_q == OP_READ && ent_valid_q) ? rd_data_q : '0;
	assign res_idx  = (op_q == OP_READ) ? 8'd0 : 8'(idx_q);
	assign res_grey = (op_q == OP_READ) ? '0 : quot_q;

	// palette memory, read data held outside the search and slot read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[count_q[IDX_W-1:0]] <= pix_q;
		end
		if (state_q == S_SCAN || state_q == S_RDREQ) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cmp_valid_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			op_q        <= OP_CLASSIFY;
			pix_q       <= '0;
			ent_q       <= '0;
			ent_valid_q <= 1'b0;
			scan_q      <= '0;
			cmp_addr_q  <= '0;
			idx_q       <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			step_q      <= '0;
			new_q       <= 1'b0;
			drop_q      <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// result valid: set when a result is loaded, cleared on its transfer
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cmp_valid_q <= 1'b0;
					if (in_xfer) begin
						op_q        <= s_tuser;
						pix_q       <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
						ent_q       <= IDX_W'(s_tdata[31:24]);
						ent_valid_q <= (CMP_W'(s_tdata[31:24]) < CMP_W'(count_q));
						scan_q      <= '0;
						idx_q       <= '0;
						rem_q       <= '0;
						quot_q      <= '0;
						step_q      <= '0;
						new_q       <= 1'b0;
						drop_q      <= 1'b0;
						state_q     <= (s_tuser == OP_READ) ? S_RDREQ : S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_valid_q <= issue;
					cmp_addr_q  <= scan_q[IDX_W-1:0];
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						idx_q   <= cmp_addr_q;
						state_q <= S_DIV;
					end else if (miss) begin
						if (room) begin
							idx_q   <= count_q[IDX_W-1:0];
							count_q <= count_q + 1'b1;
							new_q   <= 1'b1;
							state_q <= S_DIV;
						end else begin
							drop_q  <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_DIV: begin
					if (idx_q == '0) begin
						state_q <= S_DONE;
					end else begin
						rem_q  <= ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
						quot_q <= {quot_q[GREY_W-2:0], ge};
						step_q <= step_q + 1'b1;
						if (step_q == GSTEP_W'(GREY_W - 1)) begin
							state_q <= S_DONE;
						end
					end
				end
				S_RDREQ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tdata_q  <= {4'd0, 9'(count_q), ent_valid_q && (op_q == OP_READ),
							ent_rgb[7:0], ent_rgb[15:8], ent_rgb[23:16],
							drop_q, new_q, res_grey, res_idx};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// colour count never passes the palette depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(PALETTE_DEPTH))
		else $error("colour count above palette depth");

	// the count only grows by one, and only on an append
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1) && new_q)
		else $error("colour count changed without an append");

	// an appended colour and a dropped colour never share a result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(m_tdata_q[16] && m_tdata_q[17]))
		else $error("result both appended and dropped");

	// a slot read result with a valid entry never carries classify flags
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[42] |-> !m_tdata_q[16] && !m_tdata_q[17])
		else $error("read result carries classify flags");

endmodule

>>> tb/tb_colour_palette_indexer.sv
`timescale 1ns / 100ps
// testbench for the colour palette indexer: directed and random items checked against a palette model
module tb_colour_palette_indexer;
	import cpi_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = PALETTE_DEPTH + 20;

	// one input item as carried on the slave side
	typedef struct packed {
		logic       opcode;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] entry_index;
	} palette_req_t;

	// one result item as carried on the master side
	typedef struct packed {
		logic [7:0]         colour_index;
		logic [7:0]         grey_level;
		logic               was_new;
		logic               dropped_full;
		logic [7:0]         entry_red;
		logic [7:0]         entry_green;
		logic [7:0]         entry_blue;
		logic               entry_valid;
		logic [COUNT_W-1:0] colour_count;
	} palette_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// palette as the block should hold it, in first-seen order
	logic [RGB_W-1:0] known_colours [PALETTE_DEPTH];
	int               known_count = 0;

	palette_result_t expected_results [$];
	int              mismatch_count = 0;
	int              cycle_count = 0;
	bit              source_steady = 1'b0;
	bit              sink_steady = 1'b0;

	colour_palette_indexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 2 ns clock
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("colour_palette_indexer verification failed");
			$finish;
		end
	end

	// slot of a stored colour, or -1 when it is not in the palette
	function automatic int find_palette_slot(input logic [RGB_W-1:0] rgb);
		for (int i = 0; i < known_count; i++)
			if (known_colours[i] == rgb)
				return i;
		return -1;
	endfunction

	// expected result of one item; updates the palette model
	function automatic palette_result_t predict_palette_result(input palette_req_t req);
		palette_result_t  res;
		logic [RGB_W-1:0] rgb;
		int               slot;
		res = '0;
		if (req.opcode == OP_CLASSIFY) begin
			rgb  = {req.red, req.green, req.blue};
			slot = find_palette_slot(rgb);
			// unseen colour goes to the end while there is room
			if (slot < 0 && known_count < PALETTE_DEPTH) begin
				slot = known_count;
				known_colours[known_count] = rgb;
				known_count++;
				res.was_new = 1'b1;
			end
			if (slot < 0) begin
				res.dropped_full = 1'b1;
			end else begin
				res.colour_index = 8'(slot);
				res.grey_level   = (slot == 0) ? 8'd0 : 8'(255 / slot);
			end
		end else if (int'(req.entry_index) < known_count) begin
			{res.entry_red, res.entry_green, res.entry_blue} = known_colours[req.entry_index];
			res.entry_valid = 1'b1;
		end
		res.colour_count = COUNT_W'(known_count);
		return res;
	endfunction

	// random colour that the palette does not hold yet
	function automatic logic [RGB_W-1:0] fresh_colour();
		logic [RGB_W-1:0] rgb;
		do
			rgb = RGB_W'($urandom);
		while (find_palette_slot(rgb) >= 0);
		return rgb;
	endfunction

	// drive one item after a random gap and wait for its transfer
	task automatic send_item(input logic opcode, input logic [7:0] red, green, blue,
			input logic [7:0] entry_index);
		palette_req_t req;
		int           gap;
		req = {opcode, red, green, blue, entry_index};
		if ($urandom_range(0, 39) == 0)
			source_steady = !source_steady;
		gap = source_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			s_tuser  <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {entry_index, blue, green, red};
		s_tuser  <= opcode;
		do @(posedge clk); while (!s_tready);
		expected_results.insert(expected_results.size(), predict_palette_result(req));
	endtask

	// classify item; the slot field is unused and left random
	task automatic classify(input logic [RGB_W-1:0] rgb);
		send_item(OP_CLASSIFY, rgb[23:16], rgb[15:8], rgb[7:0], 8'($urandom));
	endtask

	// read item; the colour fields are unused and left random
	task automatic read_slot(input logic [7:0] slot);
		logic [RGB_W-1:0] junk;
		junk = RGB_W'($urandom);
		send_item(OP_READ, junk[23:16], junk[15:8], junk[7:0], slot);
	endtask

	// one random item: new colour, repeated colour or palette read
	task automatic send_random_item(input int new_percent);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < new_percent)
			classify(fresh_colour());
		else if (roll < new_percent + 30 && known_count > 0)
			classify(known_colours[$urandom_range(0, known_count - 1)]);
		else if ($urandom_range(0, 4) != 0 && known_count > 0)
			read_slot(8'($urandom_range(0, known_count - 1)));
		else
			read_slot(8'($urandom_range(0, 255)));
	endtask

	// reads on an empty palette, then the first colour, a repeat of it and reads of slots 0 and 1
	task automatic test_empty_palette();
		read_slot(8'h00);
		read_slot(8'hFF);
		classify(24'h000000);
		classify(24'h000000);
		read_slot(8'h00);
		read_slot(8'h01);
	endtask

	// extreme and single-channel colours, repeats, reads of slots 1 to 5 and one past the count
	task automatic test_extreme_colours();
		classify(24'hFFFFFF);
		classify(24'h800000);
		classify(24'h008000);
		classify(24'h000080);
		classify(24'hFFFFFF);
		classify(24'h000080);
		classify(24'h010000);
		for (int i = 1; i <= 5; i++)
			read_slot(8'(i));
		read_slot(8'(known_count));
	endtask

	// random mix while the palette grows
	task automatic test_random_growth();
		for (int i = 0; i < 200; i++)
			send_random_item(50);
	endtask

	// mostly new colours until every slot is taken
	task automatic test_fill_palette();
		while (known_count < PALETTE_DEPTH)
			send_random_item(70);
	endtask

	// drop on a full palette, hit and read at the last slot, hit at slot 0
	task automatic test_full_palette();
		classify(fresh_colour());
		classify(known_colours[PALETTE_DEPTH - 1]);
		read_slot(8'hFF);
		classify(known_colours[0]);
	endtask

	// random mix on a full palette, drops included
	task automatic test_random_full();
		for (int i = 0; i < 80; i++)
			send_random_item(30);
	endtask

	// field compare with report
	task automatic check_field(input string name, input logic [15:0] want, got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// receiver: random stalls, each result transfer checked against the oldest expectation
	initial begin : result_sink
		palette_result_t got;
		palette_result_t want;
		int              stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.colour_index = m_tdata[7:0];
			got.grey_level   = m_tdata[15:8];
			got.was_new      = m_tdata[16];
			got.dropped_full = m_tdata[17];
			got.entry_red    = m_tdata[25:18];
			got.entry_green  = m_tdata[33:26];
			got.entry_blue   = m_tdata[41:34];
			got.entry_valid  = m_tdata[42];
			got.colour_count = m_tdata[51:43];
			if (expected_results.size() == 0) begin
				$error("result transfer with no pending expectation");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("colour_index", 16'(want.colour_index), 16'(got.colour_index));
				check_field("grey_level", 16'(want.grey_level), 16'(got.grey_level));
				check_field("was_new", 16'(want.was_new), 16'(got.was_new));
				check_field("dropped_full", 16'(want.dropped_full), 16'(got.dropped_full));
				check_field("entry_red", 16'(want.entry_red), 16'(got.entry_red));
				check_field("entry_green", 16'(want.entry_green), 16'(got.entry_green));
				check_field("entry_blue", 16'(want.entry_blue), 16'(got.entry_blue));
				check_field("entry_valid", 16'(want.entry_valid), 16'(got.entry_valid));
				check_field("colour_count", 16'(want.colour_count), 16'(got.colour_count));
			end
		end
	end

	// reset, test sequence and end of run
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_CLASSIFY;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_palette();
		test_extreme_colours();
		test_random_growth();
		test_fill_palette();
		test_full_palette();
		test_random_full();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("colour_palette_indexer verification clean");
		else
			$display("colour_palette_indexer verification failed");
		$finish;
	end

endmodule
